### hdl/lfp_pkg.sv
// ----------------------------------------------------------------------------
// lfp_pkg
// Shared constants, codes and types of the length-prefixed frame parser.
// ----------------------------------------------------------------------------
package lfp_pkg;

	localparam int BUF_DEPTH = 32;
	localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 6;
	localparam int CFG_IDX_W = 1;
	localparam int RES_DEPTH = 4;
	localparam int RES_AW    = $clog2(RES_DEPTH);

	localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'd1;

	localparam logic [BYTE_W-1:0] HEADER_RESET = 8'd170;
	localparam logic [LEN_W-1:0]  LIMIT_RESET  = 6'd32;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_LENGTH,
		PH_CMD,
		PH_DATA,
		PH_CHECK
	} phase_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} back_state_t;

	typedef struct packed {
		logic [BYTE_W-1:0] cmd;
		logic [LEN_W-1:0]  len;
	} frame_desc_t;

	typedef struct packed {
		logic              en;
		logic [BUF_AW-1:0] addr;
		logic [BYTE_W-1:0] data;
	} buf_wr_t;

	typedef struct packed {
		logic              is_head;
		logic [BYTE_W-1:0] cmd;
		logic [LEN_W-1:0]  len;
		logic [BYTE_W-1:0] payload;
		logic              last;
	} result_t;

endpackage

### hdl/lfp_front.sv
// ----------------------------------------------------------------------------
// lfp_front
// Byte parser: hunts for the header, checks length and checksum, stores the
// payload and hands a descriptor of each valid frame to the back end.
// ----------------------------------------------------------------------------
module lfp_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lfp_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [lfp_pkg::BYTE_W-1:0]       cfg_data,
	input  logic                             push,
	input  logic [lfp_pkg::BYTE_W-1:0]       rx_byte,
	output logic                             full,
	input  logic                             back_busy,
	input  logic                             desc_full,
	output logic                             desc_push,
	output lfp_pkg::frame_desc_t             desc,
	output lfp_pkg::buf_wr_t                 wr
);
	import lfp_pkg::*;

	phase_t             phase_q, phase_d;
	logic [BYTE_W-1:0]  header_q;
	logic [LEN_W-1:0]   limit_q;
	logic [LEN_W-1:0]   limit_eff;
	logic [LEN_W-1:0]   len_q;
	logic [BYTE_W-1:0]  cmd_q;
	logic [BYTE_W-1:0]  sum_q;
	logic [LEN_W-1:0]   count_q;
	logic [LEN_W-1:0]   count_inc;
	logic               accept;
	logic               len_ok;

	assign limit_eff = (limit_q > LEN_W'(BUF_DEPTH)) ? LEN_W'(BUF_DEPTH) : limit_q;
	assign len_ok    = rx_byte <= BYTE_W'(limit_eff);
	assign count_inc = count_q + LEN_W'(1);
	assign accept    = push & ~full;

	always_comb begin
		full = 1'b0;
		case (phase_q)
			PH_DATA:  full = back_busy;
			PH_CHECK: full = desc_full;
			default:  full = 1'b0;
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			case (phase_q)
				PH_HEADER: if (rx_byte == header_q) phase_d = PH_LENGTH;
				PH_LENGTH: phase_d = len_ok ? PH_CMD : PH_HEADER;
				PH_CMD:    phase_d = (len_q != '0) ? PH_DATA : PH_CHECK;
				PH_DATA:   if (count_inc >= len_q) phase_d = PH_CHECK;
				PH_CHECK:  phase_d = PH_HEADER;
				default:   phase_d = PH_HEADER;
			endcase
		end
	end

	always_comb begin
		desc_push = 1'b0;
		wr.en     = 1'b0;
		wr.addr   = count_q[BUF_AW-1:0];
		wr.data   = rx_byte;
		desc.cmd  = cmd_q;
		desc.len  = len_q;
		case (phase_q)
			PH_DATA:  wr.en = accept & (count_q < LEN_W'(BUF_DEPTH));
			PH_CHECK: desc_push = accept & (rx_byte == sum_q);
			default: begin
				desc_push = 1'b0;
				wr.en     = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
			limit_q  <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_HEADER: header_q <= cfg_data;
				CFG_LIMIT:  limit_q  <= cfg_data[LEN_W-1:0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			len_q   <= '0;
			cmd_q   <= '0;
			sum_q   <= '0;
			count_q <= '0;
		end else begin
			phase_q <= phase_d;
			if (accept) begin
				case (phase_q)
					PH_LENGTH: begin
						if (len_ok) begin
							len_q <= rx_byte[LEN_W-1:0];
							sum_q <= rx_byte;
						end
					end
					PH_CMD: begin
						cmd_q   <= rx_byte;
						sum_q   <= sum_q + rx_byte;
						count_q <= '0;
					end
					PH_DATA: begin
						count_q <= count_inc;
						sum_q   <= sum_q + rx_byte;
					end
					default: ;
				endcase
			end
		end
	end

endmodule

### hdl/lfp_desc_q.sv
// ----------------------------------------------------------------------------
// lfp_desc_q
// Two-entry queue of validated frame descriptors between front and back.
// ----------------------------------------------------------------------------
module lfp_desc_q (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  lfp_pkg::frame_desc_t  din,
	output logic                  full,
	input  logic                  pop,
	output lfp_pkg::frame_desc_t  dout,
	output logic                  empty
);
	import lfp_pkg::*;

	frame_desc_t  entry_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;
	logic         do_push, do_pop;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign dout    = entry_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= ~wp_q;
			if (do_pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

### hdl/lfp_back.sv
// ----------------------------------------------------------------------------
// lfp_back
// Frame replay: holds the payload buffer, emits the head and payload results
// of each descriptor and queues them toward the result port.
// ----------------------------------------------------------------------------
module lfp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lfp_pkg::buf_wr_t      wr,
	input  logic                  desc_empty,
	input  lfp_pkg::frame_desc_t  desc,
	output logic                  desc_pop,
	output logic                  busy,
	input  logic                  pop,
	output logic                  empty,
	output lfp_pkg::result_t      res
);
	import lfp_pkg::*;

	logic [BYTE_W-1:0]  mem [BUF_DEPTH];

	back_state_t        state_q, state_d;
	logic [BYTE_W-1:0]  cmd_q;
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   idx_q;
	logic [LEN_W-1:0]   idx_inc;

	logic               issue, room;
	logic               rd_en;
	logic [BUF_AW-1:0]  rd_addr;
	logic               iss_head, iss_last;
	logic [BYTE_W-1:0]  iss_cmd;
	logic [LEN_W-1:0]   iss_len;

	logic               vld_s1, head_s1, last_s1;
	logic [BYTE_W-1:0]  cmd_s1, rd_data_s1;
	logic [LEN_W-1:0]   len_s1;

	result_t            fifo_q [RES_DEPTH];
	result_t            fifo_in;
	logic [RES_AW-1:0]  wp_q, rp_q;
	logic [RES_AW:0]    cnt_q;
	logic               do_pop;

	assign idx_inc = idx_q + LEN_W'(1);
	assign room    = (cnt_q + (RES_AW+1)'(vld_s1)) < (RES_AW+1)'(RES_DEPTH);
	assign issue   = room & ((state_q == BK_RUN) | ~desc_empty);
	assign busy    = ~desc_empty | (state_q == BK_RUN);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: if (issue && desc.len != '0) state_d = BK_RUN;
			BK_RUN:  if (issue && idx_inc == len_q) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		desc_pop = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = idx_q[BUF_AW-1:0];
		iss_head = 1'b0;
		iss_last = 1'b0;
		iss_cmd  = cmd_q;
		iss_len  = len_q;
		case (state_q)
			BK_IDLE: begin
				desc_pop = issue;
				iss_head = 1'b1;
				iss_last = desc.len == '0;
				iss_cmd  = desc.cmd;
				iss_len  = desc.len;
			end
			BK_RUN: begin
				rd_en    = issue;
				iss_last = idx_inc == len_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr.en) mem[wr.addr] <= wr.data;
		if (rd_en) rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			idx_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			if (issue) begin
				if (state_q == BK_IDLE) idx_q <= '0;
				else                    idx_q <= idx_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue && state_q == BK_IDLE) begin
			cmd_q <= desc.cmd;
			len_q <= desc.len;
		end
		if (issue) begin
			head_s1 <= iss_head;
			last_s1 <= iss_last;
			cmd_s1  <= iss_cmd;
			len_s1  <= iss_len;
		end
	end

	assign fifo_in.is_head = head_s1;
	assign fifo_in.cmd     = cmd_s1;
	assign fifo_in.len     = len_s1;
	assign fifo_in.payload = head_s1 ? '0 : rd_data_s1;
	assign fifo_in.last    = last_s1;

	assign empty  = cnt_q == '0;
	assign do_pop = pop & ~empty;
	assign res    = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (vld_s1) fifo_q[wp_q] <= fifo_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (vld_s1) wp_q <= wp_q + RES_AW'(1);
			if (do_pop) rp_q <= rp_q + RES_AW'(1);
			cnt_q <= cnt_q + (RES_AW+1)'(vld_s1) - (RES_AW+1)'(do_pop);
		end
	end

endmodule

### hdl/length_prefixed_frame_parser.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser
// Serial frame parser with header hunt, length limit and additive checksum.
//
//   channel   direction  handshake         payload
//   input     in         push / full       rx_byte
//   result    out        pop / empty       is_head frame_cmd frame_len
//                                          payload_byte last_item
//   config    in         cfg_we            cfg_idx cfg_data
//
// The parser takes one byte per cycle while full is low. A valid frame of
// length N yields N+1 results, one per cycle from the replay unit while the
// result queue has room, via the buffer read register and the result queue.
// full rises on a payload byte while the back end is busy, and on the checksum
// byte while the descriptor queue is full. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lfp_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [lfp_pkg::BYTE_W-1:0]     cfg_data,
	input  logic                           push,
	output logic                           full,
	input  logic [lfp_pkg::BYTE_W-1:0]     rx_byte,
	output logic                           empty,
	input  logic                           pop,
	output logic                           is_head,
	output logic [lfp_pkg::BYTE_W-1:0]     frame_cmd,
	output logic [lfp_pkg::LEN_W-1:0]      frame_len,
	output logic [lfp_pkg::BYTE_W-1:0]     payload_byte,
	output logic                           last_item
);
	import lfp_pkg::*;

	frame_desc_t  front_desc, back_desc;
	buf_wr_t      buf_wr;
	result_t      res;
	logic         desc_push, desc_full, desc_pop, desc_empty;
	logic         back_busy;

	lfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.push      (push),
		.rx_byte   (rx_byte),
		.full      (full),
		.back_busy (back_busy),
		.desc_full (desc_full),
		.desc_push (desc_push),
		.desc      (front_desc),
		.wr        (buf_wr)
	);

	lfp_desc_q u_desc_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (desc_push),
		.din    (front_desc),
		.full   (desc_full),
		.pop    (desc_pop),
		.dout   (back_desc),
		.empty  (desc_empty)
	);

	lfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (buf_wr),
		.desc_empty (desc_empty),
		.desc       (back_desc),
		.desc_pop   (desc_pop),
		.busy       (back_busy),
		.pop        (pop),
		.empty      (empty),
		.res        (res)
	);

	assign is_head      = res.is_head;
	assign frame_cmd    = res.cmd;
	assign frame_len    = res.len;
	assign payload_byte = res.payload;
	assign last_item    = res.last;

endmodule

### test/length_prefixed_frame_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser_tb
// Self-checking bench for the frame parser. Feeds header-framed byte streams
// (good frames, bad checksums, oversize lengths, truncated frames and noise)
// under several register settings and idle patterns. A scoreboard predicts
// the replayed head and payload results and checks each popped transaction.
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser_tb;
	import lfp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef enum {FILL_RAND, FILL_ZERO, FILL_ONES} fill_t;

	class frame_scoreboard;
		logic [BYTE_W-1:0] hdr_val;
		logic [LEN_W-1:0]  len_limit;
		phase_t            phase;
		logic [LEN_W-1:0]  len;
		logic [BYTE_W-1:0] cmd;
		logic [BYTE_W-1:0] sum;
		logic [LEN_W-1:0]  count;
		logic [BYTE_W-1:0] store [BUF_DEPTH];
		result_t           replay_q [$];
		int                errors;

		function new();
			hdr_val   = HEADER_RESET;
			len_limit = LIMIT_RESET;
			phase     = PH_HEADER;
			len       = '0;
			cmd       = '0;
			sum       = '0;
			count     = '0;
			errors    = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
			case (idx)
				CFG_HEADER: hdr_val = data;
				CFG_LIMIT:  len_limit = data[LEN_W-1:0];
				default: ;
			endcase
		endfunction

		function int eff_limit();
			return (len_limit > BUF_DEPTH) ? BUF_DEPTH : int'(len_limit);
		endfunction

		function void add_result(logic head, logic [BYTE_W-1:0] pay, logic last);
			result_t r;
			r.is_head = head;
			r.cmd     = cmd;
			r.len     = len;
			r.payload = pay;
			r.last    = last;
			replay_q.push_back(r);
		endfunction

		function void take_byte(logic [BYTE_W-1:0] b);
			case (phase)
				PH_HEADER: begin
					if (b == hdr_val)
						phase = PH_LENGTH;
				end
				PH_LENGTH: begin
					if (b <= eff_limit()) begin
						len   = b[LEN_W-1:0];
						sum   = b;
						phase = PH_CMD;
					end else begin
						phase = PH_HEADER;
					end
				end
				PH_CMD: begin
					cmd   = b;
					sum   = sum + b;
					count = '0;
					phase = (len != 0) ? PH_DATA : PH_CHECK;
				end
				PH_DATA: begin
					if (count < BUF_DEPTH)
						store[count[BUF_AW-1:0]] = b;
					count = count + 1'b1;
					sum   = sum + b;
					if (count >= len)
						phase = PH_CHECK;
				end
				PH_CHECK: begin
					if (b == sum) begin
						add_result(1'b1, '0, len == 0);
						for (int i = 0; i < len && i < BUF_DEPTH; i++)
							add_result(1'b0, store[i], i + 1 == len);
					end
					phase = PH_HEADER;
				end
				default: phase = PH_HEADER;
			endcase
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (replay_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, actual %h", $time, got);
				return;
			end
			want = replay_q.pop_front();
			if (got.is_head !== want.is_head) begin
				errors++;
				$display("%0t: is_head expected %0d actual %0d", $time, want.is_head,
					got.is_head);
			end
			if (got.cmd !== want.cmd) begin
				errors++;
				$display("%0t: frame_cmd expected %h actual %h", $time, want.cmd, got.cmd);
			end
			if (got.len !== want.len) begin
				errors++;
				$display("%0t: frame_len expected %0d actual %0d", $time, want.len, got.len);
			end
			if (got.payload !== want.payload) begin
				errors++;
				$display("%0t: payload_byte expected %h actual %h", $time, want.payload,
					got.payload);
			end
			if (got.last !== want.last) begin
				errors++;
				$display("%0t: last_item expected %0d actual %0d", $time, want.last,
					got.last);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [BYTE_W-1:0]    cfg_data;
	logic                 push;
	logic                 full;
	logic [BYTE_W-1:0]    rx_byte;
	logic                 empty;
	logic                 pop;
	logic                 is_head;
	logic [BYTE_W-1:0]    frame_cmd;
	logic [LEN_W-1:0]     frame_len;
	logic [BYTE_W-1:0]    payload_byte;
	logic                 last_item;

	frame_scoreboard sb = new();
	int              send_idle_pct;
	int              recv_stall_pct;
	int              hold_left;
	int unsigned     cycle_count = 0;

	length_prefixed_frame_parser u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.push         (push),
		.full         (full),
		.rx_byte      (rx_byte),
		.empty        (empty),
		.pop          (pop),
		.is_head      (is_head),
		.frame_cmd    (frame_cmd),
		.frame_len    (frame_len),
		.payload_byte (payload_byte),
		.last_item    (last_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && push && !full)
			sb.take_byte(rx_byte);
		if (arst_n && pop && !empty)
			sb.check_result({is_head, frame_cmd, frame_len, payload_byte, last_item});
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	// result side: long hold-off first, then random stalls
	initial begin
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else begin
				pop <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push    <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic send_frame(input logic [BYTE_W-1:0] cmd, input int n, input fill_t fill,
		input bit bad_sum);
		logic [BYTE_W-1:0] b;
		logic [BYTE_W-1:0] sum;
		sum = n[BYTE_W-1:0] + cmd;
		send_byte(sb.hdr_val);
		send_byte(n[BYTE_W-1:0]);
		send_byte(cmd);
		for (int i = 0; i < n; i++) begin
			case (fill)
				FILL_ZERO: b = 8'h00;
				FILL_ONES: b = 8'hFF;
				default:   b = 8'($urandom);
			endcase
			sum = sum + b;
			send_byte(b);
		end
		send_byte(bad_sum ? sum + 8'($urandom_range(1, 255)) : sum);
	endtask

	task automatic run_random(input int n_items);
		int                sent;
		int                kind;
		int                eff;
		int                n;
		logic [BYTE_W-1:0] b;
		sent = 0;
		eff  = sb.eff_limit();
		while (sent < n_items) begin
			kind = $urandom_range(99);
			n = ($urandom_range(99) < 8) ? eff : $urandom_range(eff < 8 ? eff : 8);
			if (kind < 70) begin
				send_frame(8'($urandom), n, FILL_RAND, 1'b0);
				sent += n + 4;
			end else if (kind < 80) begin
				send_frame(8'($urandom), n, FILL_RAND, 1'b1);
				sent += n + 4;
			end else if (kind < 88) begin
				send_byte(sb.hdr_val);
				send_byte(8'($urandom_range(eff + 1, 255)));
				sent += 2;
			end else if (kind < 94) begin
				repeat ($urandom_range(1, 4)) begin
					do b = 8'($urandom); while (b == sb.hdr_val);
					send_byte(b);
					sent++;
				end
			end else begin
				// cut the frame short before its checksum
				send_byte(sb.hdr_val);
				send_byte(n[BYTE_W-1:0]);
				repeat ($urandom_range(0, n + 1)) begin
					send_byte(8'($urandom));
					sent++;
				end
				sent += 2;
			end
		end
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (sb.replay_q.size() != 0 || hold_left > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_regs(input logic [BYTE_W-1:0] hdr, input logic [LEN_W-1:0] lim);
		logic [BYTE_W-1:0] lim_data;
		lim_data = {2'($urandom), lim};
		cfg_we   <= 1'b1;
		cfg_idx  <= CFG_HEADER;
		cfg_data <= hdr;
		@(posedge clk);
		sb.write_reg(CFG_HEADER, hdr);
		cfg_idx  <= CFG_LIMIT;
		cfg_data <= lim_data;
		@(posedge clk);
		sb.write_reg(CFG_LIMIT, lim_data);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_idx        <= CFG_HEADER;
		cfg_data       <= '0;
		push           <= 1'b0;
		rx_byte        <= '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left      = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero length, extremes, oversize length, bad checksum
		send_frame(8'h00, 0, FILL_ZERO, 1'b0);
		send_frame(8'hFF, 1, FILL_ONES, 1'b0);
		send_byte(sb.hdr_val);
		send_byte(8'd33);
		send_frame(8'h3C, 2, FILL_RAND, 1'b1);
		send_frame(8'h81, 3, FILL_ZERO, 1'b0);
		drain();

		set_regs(8'h00, 6'd63);
		run_random(45);
		drain();

		set_regs(8'hFF, 6'd0);
		send_idle_pct = 69;
		run_random(45);
		drain();

		set_regs(8'h5A, 6'd32);
		send_idle_pct  = 0;
		recv_stall_pct = 69;
		run_random(45);
		drain();

		set_regs(8'($urandom), 6'($urandom_range(1, 31)));
		send_idle_pct  = 28;
		recv_stall_pct = 28;
		run_random(45);
		drain();

		// hold the result side so the block backs up and stalls input
		set_regs(HEADER_RESET, LIMIT_RESET);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left      = 300;
		run_random(45);
		drain();

		if (sb.errors == 0 && sb.replay_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### length_prefixed_frame_parser.f
hdl/lfp_pkg.sv
hdl/lfp_front.sv
hdl/lfp_desc_q.sv
hdl/lfp_back.sv
hdl/length_prefixed_frame_parser.sv
test/length_prefixed_frame_parser_tb.sv
